>>> sv/usbsb_pkg.sv
// ----------------------------------------------------------------------------
// usbsb_pkg
// Types, codes and constant tables shared by the request decoder modules.
// ----------------------------------------------------------------------------
package usbsb_pkg;

	// Event opcodes of one input beat
	localparam logic [1:0] OP_REQUEST   = 2'd0;
	localparam logic [1:0] OP_BUS_RESET = 2'd1;
	localparam logic [1:0] OP_SOF       = 2'd2;

	// Vendor request numbers
	localparam logic [7:0] REQ_RESET      = 8'h00;
	localparam logic [7:0] REQ_MODEM_CTRL = 8'h01;
	localparam logic [7:0] REQ_FLOW_CTRL  = 8'h02;
	localparam logic [7:0] REQ_SET_BAUD   = 8'h03;
	localparam logic [7:0] REQ_SET_DATA   = 8'h04;
	localparam logic [7:0] REQ_POLL_MODEM = 8'h05;
	localparam logic [7:0] REQ_EVENT_CHAR = 8'h06;
	localparam logic [7:0] REQ_ERROR_CHAR = 8'h07;
	localparam logic [7:0] REQ_SET_LAT    = 8'h09;
	localparam logic [7:0] REQ_GET_LAT    = 8'h0A;
	localparam logic [7:0] REQ_NOP_B      = 8'h0B;
	localparam logic [7:0] REQ_NOP_C      = 8'h0C;
	localparam logic [7:0] REQ_READ_ROM   = 8'h90;

	// Modem control values
	localparam logic [15:0] MODEM_DTR_HI = 16'h0101;
	localparam logic [15:0] MODEM_DTR_LO = 16'h0100;
	localparam logic [15:0] MODEM_RTS_HI = 16'h0202;
	localparam logic [15:0] MODEM_RTS_LO = 16'h0200;

	// Modem line select codes
	localparam logic [1:0] LINE_NONE = 2'd0;
	localparam logic [1:0] LINE_DTR  = 2'd1;
	localparam logic [1:0] LINE_RTS  = 2'd2;

	// Reply lengths
	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_BYTE = 2'd1;
	localparam logic [1:0] REPLY_WORD = 2'd2;

	// Rates and reset values
	localparam logic [21:0] BAUD_MAX   = 22'd3000000;
	localparam logic [21:0] BAUD_ALT   = 22'd2000000;
	localparam logic [21:0] BAUD_RESET = 22'd1200;
	localparam logic [7:0]  LAT_RESET  = 8'h10;
	localparam logic [7:0]  DATA_BITS_DEFAULT = 8'd8;
	localparam logic [15:0] MODEM_STATUS = 16'h6010;
	localparam logic [13:0] DIV_MANT_MASK = 14'h3fff;

	// Divider geometry: 48 MHz over an 18-bit divisor
	localparam int DIV_Q_W = 26;
	localparam int DIV_D_W = 18;
	localparam int DIV_STEPS = DIV_Q_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic [DIV_Q_W-1:0] DIV_DIVIDEND = 26'd48000000;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_index;
	} in_item_t;

	typedef struct packed {
		logic        request_status;
		logic [1:0]  reply_length;
		logic [15:0] reply_word;
		logic        purge_strobe;
		logic [1:0]  modem_line_write;
		logic        modem_line_level;
		logic        coding_write;
		logic [21:0] line_baud;
		logic [7:0]  line_data_bits;
		logic [7:0]  line_parity;
		logic [4:0]  line_stop_bits;
		logic [31:0] frame_count;
	} out_item_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_BUSRST,
		CMD_SOF,
		CMD_STALL,
		CMD_ROM,
		CMD_PURGE,
		CMD_MODEM,
		CMD_BAUD,
		CMD_DATA,
		CMD_POLL,
		CMD_SETLAT,
		CMD_GETLAT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [15:0]          value;
		logic [15:0]          index;
		logic [DIV_D_W-1:0]   divisor;
		logic                 fixed_en;
		logic [21:0]          fixed_rate;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} back_state_t;

	// Eighth-fraction code to sixteenths of the divisor
	function automatic logic [3:0] frac16(input logic [2:0] sel);
		logic [3:0] f;
		case (sel)
			3'd0: f = 4'd0;
			3'd1: f = 4'd8;
			3'd2: f = 4'd4;
			3'd3: f = 4'd2;
			3'd4: f = 4'd6;
			3'd5: f = 4'd10;
			3'd6: f = 4'd12;
			3'd7: f = 4'd14;
			default: f = 4'd0;
		endcase
		return f;
	endfunction

	// Configuration ROM, 64 words
	function automatic logic [15:0] rom_word(input logic [5:0] addr);
		logic [15:0] w;
		case (addr)
			6'd0:  w = 16'h0800;
			6'd1:  w = 16'h0403;
			6'd2:  w = 16'h6010;
			6'd3:  w = 16'h0500;
			6'd4:  w = 16'h3280;
			6'd5:  w = 16'h0000;
			6'd6:  w = 16'h0200;
			6'd7:  w = 16'h1096;
			6'd8:  w = 16'h1aa6;
			6'd9:  w = 16'h0000;
			6'd10: w = 16'h0046;
			6'd11: w = 16'h0310;
			6'd12: w = 16'h004f;
			6'd13: w = 16'h0070;
			6'd14: w = 16'h0065;
			6'd15: w = 16'h006e;
			6'd16: w = 16'h002d;
			6'd17: w = 16'h0045;
			6'd18: w = 16'h0043;
			6'd19: w = 16'h031a;
			6'd20: w = 16'h0055;
			6'd21: w = 16'h0053;
			6'd22: w = 16'h0042;
			6'd23: w = 16'h0020;
			6'd24: w = 16'h0044;
			6'd25: w = 16'h0065;
			6'd26: w = 16'h0062;
			6'd27: w = 16'h0075;
			6'd28: w = 16'h0067;
			6'd29: w = 16'h0067;
			6'd30: w = 16'h0065;
			6'd31: w = 16'h0072;
			6'd63: w = 16'h1027;
			default: w = 16'h0000;
		endcase
		return w;
	endfunction

endpackage

>>> sv/usbsb_fifo.sv
// ----------------------------------------------------------------------------
// usbsb_fifo
// Small first-in first-out queue of packed beats with push/full, pop/empty.
// ----------------------------------------------------------------------------
module usbsb_fifo #(
	parameter type item_t = logic,
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t wr_data,
	input  logic  pop,
	output logic  empty,
	output item_t rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_en;
	logic             rd_en;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign wr_en   = push && !full;
	assign rd_en   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/usbsb_front.sv
// ----------------------------------------------------------------------------
// usbsb_front
// Classifies one input beat into a command and prepares the baud divisor.
// ----------------------------------------------------------------------------
module usbsb_front (
	input  usbsb_pkg::in_item_t item,
	output usbsb_pkg::cmd_t     cmd
);
	logic [23:0]                    word;
	logic [usbsb_pkg::DIV_D_W-1:0]  divisor;

	assign word    = {item.request_index[15:8], item.request_value};
	assign divisor = {word[13:0] & usbsb_pkg::DIV_MANT_MASK, 4'b0000}
		| {14'd0, usbsb_pkg::frac16(word[16:14])};

	always_comb begin
		cmd            = '0;
		cmd.value      = item.request_value;
		cmd.index      = item.request_index;
		cmd.divisor    = divisor;
		cmd.kind       = usbsb_pkg::CMD_NONE;
		// fixed rates skip the divider
		if (word == 24'd0) begin
			cmd.fixed_en   = 1'b1;
			cmd.fixed_rate = usbsb_pkg::BAUD_MAX;
		end else if (word == 24'd1) begin
			cmd.fixed_en   = 1'b1;
			cmd.fixed_rate = usbsb_pkg::BAUD_ALT;
		end else if (divisor == '0) begin
			cmd.fixed_en   = 1'b1;
			cmd.fixed_rate = usbsb_pkg::BAUD_MAX;
		end
		case (item.opcode)
			usbsb_pkg::OP_BUS_RESET: cmd.kind = usbsb_pkg::CMD_BUSRST;
			usbsb_pkg::OP_SOF:       cmd.kind = usbsb_pkg::CMD_SOF;
			usbsb_pkg::OP_REQUEST: begin
				case (item.request_code)
					usbsb_pkg::REQ_READ_ROM:   cmd.kind = usbsb_pkg::CMD_ROM;
					usbsb_pkg::REQ_RESET:      cmd.kind = usbsb_pkg::CMD_PURGE;
					usbsb_pkg::REQ_MODEM_CTRL: cmd.kind = usbsb_pkg::CMD_MODEM;
					usbsb_pkg::REQ_SET_BAUD:   cmd.kind = usbsb_pkg::CMD_BAUD;
					usbsb_pkg::REQ_SET_DATA:   cmd.kind = usbsb_pkg::CMD_DATA;
					usbsb_pkg::REQ_POLL_MODEM: cmd.kind = usbsb_pkg::CMD_POLL;
					usbsb_pkg::REQ_SET_LAT:    cmd.kind = usbsb_pkg::CMD_SETLAT;
					usbsb_pkg::REQ_GET_LAT:    cmd.kind = usbsb_pkg::CMD_GETLAT;
					usbsb_pkg::REQ_FLOW_CTRL,
					usbsb_pkg::REQ_EVENT_CHAR,
					usbsb_pkg::REQ_ERROR_CHAR,
					usbsb_pkg::REQ_NOP_B,
					usbsb_pkg::REQ_NOP_C:      cmd.kind = usbsb_pkg::CMD_NONE;
					default:                   cmd.kind = usbsb_pkg::CMD_STALL;
				endcase
			end
			default: cmd.kind = usbsb_pkg::CMD_NONE;
		endcase
	end

endmodule

>>> sv/usbsb_back.sv
// ----------------------------------------------------------------------------
// usbsb_back
// Executes commands against the bridge state; runs the baud divider.
// ----------------------------------------------------------------------------
module usbsb_back #(
	parameter int ROM_WORDS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  usbsb_pkg::cmd_t      cmd,
	input  logic                 cmd_empty,
	output logic                 cmd_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output usbsb_pkg::out_item_t res_data
);
	localparam logic [16:0] ROM_LIMIT = 17'(ROM_WORDS);
	localparam logic [usbsb_pkg::STEP_W-1:0] STEP_LAST =
		usbsb_pkg::STEP_W'(usbsb_pkg::DIV_STEPS - 1);

	usbsb_pkg::back_state_t state_q, state_d;
	logic [21:0] baud_q, baud_d;
	logic [7:0]  lat1_q, lat1_d;
	logic [7:0]  lat2_q, lat2_d;
	logic [31:0] frame_q, frame_d;

	logic [usbsb_pkg::DIV_D_W-1:0] div_q;
	logic [usbsb_pkg::DIV_D_W-1:0] rem_q;
	logic [usbsb_pkg::DIV_Q_W-1:0] quo_q;
	logic [usbsb_pkg::STEP_W-1:0]  step_q;
	logic [usbsb_pkg::DIV_D_W:0]   rem_sh;
	logic [usbsb_pkg::DIV_D_W:0]   rem_sub;
	logic                          q_bit;
	logic [21:0]                   quo_sat;
	logic                          div_load;
	logic                          div_step;

	function automatic usbsb_pkg::out_item_t baud_reply(input logic [21:0] rate);
		usbsb_pkg::out_item_t r;
		r = '0;
		if (rate != usbsb_pkg::BAUD_RESET) begin
			r.coding_write   = 1'b1;
			r.line_baud      = rate;
			r.line_data_bits = usbsb_pkg::DATA_BITS_DEFAULT;
		end
		return r;
	endfunction

	// one restoring step per cycle
	assign rem_sh  = {rem_q, quo_q[usbsb_pkg::DIV_Q_W-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign q_bit   = (rem_sh >= {1'b0, div_q});
	assign quo_sat = (quo_q > usbsb_pkg::DIV_Q_W'(usbsb_pkg::BAUD_MAX))
		? usbsb_pkg::BAUD_MAX : quo_q[21:0];

	always_ff @(posedge clk) begin
		if (div_load) begin
			div_q  <= cmd.divisor;
			rem_q  <= '0;
			quo_q  <= usbsb_pkg::DIV_DIVIDEND;
			step_q <= '0;
		end else if (div_step) begin
			rem_q  <= q_bit ? rem_sub[usbsb_pkg::DIV_D_W-1:0] : rem_sh[usbsb_pkg::DIV_D_W-1:0];
			quo_q  <= {quo_q[usbsb_pkg::DIV_Q_W-2:0], q_bit};
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= usbsb_pkg::BK_IDLE;
			baud_q  <= usbsb_pkg::BAUD_RESET;
			lat1_q  <= usbsb_pkg::LAT_RESET;
			lat2_q  <= usbsb_pkg::LAT_RESET;
			frame_q <= '0;
		end else begin
			state_q <= state_d;
			baud_q  <= baud_d;
			lat1_q  <= lat1_d;
			lat2_q  <= lat2_d;
			frame_q <= frame_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		baud_d   = baud_q;
		lat1_d   = lat1_q;
		lat2_d   = lat2_q;
		frame_d  = frame_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		div_load = 1'b0;
		div_step = 1'b0;
		res_data = '0;
		case (state_q)
			usbsb_pkg::BK_IDLE: begin
				if (!cmd_empty) begin
					if (cmd.kind == usbsb_pkg::CMD_BAUD && !cmd.fixed_en) begin
						cmd_pop  = 1'b1;
						div_load = 1'b1;
						state_d  = usbsb_pkg::BK_DIV;
					end else if (!res_full) begin
						cmd_pop  = 1'b1;
						res_push = 1'b1;
						case (cmd.kind)
							usbsb_pkg::CMD_BUSRST: begin
								lat1_d  = usbsb_pkg::LAT_RESET;
								lat2_d  = usbsb_pkg::LAT_RESET;
								frame_d = '0;
							end
							usbsb_pkg::CMD_SOF: frame_d = frame_q + 1'b1;
							usbsb_pkg::CMD_STALL: res_data.request_status = 1'b1;
							usbsb_pkg::CMD_ROM: begin
								res_data.reply_length = usbsb_pkg::REPLY_WORD;
								if ({1'b0, cmd.index} < ROM_LIMIT && cmd.index[15:6] == '0) begin
									res_data.reply_word = usbsb_pkg::rom_word(cmd.index[5:0]);
								end
							end
							usbsb_pkg::CMD_PURGE:
								res_data.purge_strobe = (cmd.index[15:1] == '0);
							usbsb_pkg::CMD_MODEM: begin
								case (cmd.value)
									usbsb_pkg::MODEM_DTR_HI: begin
										res_data.modem_line_write = usbsb_pkg::LINE_DTR;
										res_data.modem_line_level = 1'b1;
									end
									usbsb_pkg::MODEM_DTR_LO:
										res_data.modem_line_write = usbsb_pkg::LINE_DTR;
									usbsb_pkg::MODEM_RTS_HI: begin
										res_data.modem_line_write = usbsb_pkg::LINE_RTS;
										res_data.modem_line_level = 1'b1;
									end
									usbsb_pkg::MODEM_RTS_LO:
										res_data.modem_line_write = usbsb_pkg::LINE_RTS;
									default: res_data.modem_line_write = usbsb_pkg::LINE_NONE;
								endcase
							end
							usbsb_pkg::CMD_BAUD: begin
								baud_d   = cmd.fixed_rate;
								res_data = baud_reply(cmd.fixed_rate);
							end
							usbsb_pkg::CMD_DATA: begin
								if (baud_q != usbsb_pkg::BAUD_RESET) begin
									res_data.coding_write   = 1'b1;
									res_data.line_baud      = baud_q;
									res_data.line_data_bits = cmd.value[7:0];
									res_data.line_parity    = cmd.value[15:8];
									res_data.line_stop_bits = cmd.value[15:11];
								end
							end
							usbsb_pkg::CMD_POLL: begin
								res_data.reply_length = usbsb_pkg::REPLY_WORD;
								res_data.reply_word   = usbsb_pkg::MODEM_STATUS;
							end
							usbsb_pkg::CMD_SETLAT: begin
								if (cmd.index == 16'd1) begin
									lat1_d = cmd.value[7:0];
								end else begin
									lat2_d = cmd.value[7:0];
								end
							end
							usbsb_pkg::CMD_GETLAT: begin
								res_data.reply_length = usbsb_pkg::REPLY_BYTE;
								res_data.reply_word   = {8'd0, (cmd.index == 16'd1) ? lat1_q : lat2_q};
							end
							default: ;
						endcase
					end
				end
			end
			usbsb_pkg::BK_DIV: begin
				div_step = 1'b1;
				if (step_q == STEP_LAST) begin
					state_d = usbsb_pkg::BK_FIN;
				end
			end
			usbsb_pkg::BK_FIN: begin
				res_data = baud_reply(quo_sat);
				if (!res_full) begin
					res_push = 1'b1;
					baud_d   = quo_sat;
					state_d  = usbsb_pkg::BK_IDLE;
				end
			end
			default: state_d = usbsb_pkg::BK_IDLE;
		endcase
		res_data.frame_count = frame_d;
	end

endmodule

>>> sv/usb_serial_bridge_request_decoder.sv
// ----------------------------------------------------------------------------
// usb_serial_bridge_request_decoder
// Vendor control request decoder of a USB-to-serial bridge, with bus-reset
// and start-of-frame handling.
// ----------------------------------------------------------------------------
// Each input beat is one event (vendor setup request, bus reset or start of
// frame) and yields exactly one result beat, in order. Both sides look like a
// queue: push/full in, empty/pop out. The front classifies a beat in the
// cycle it is pushed and parks it in a two-entry command queue; the back
// executes commands one at a time and places results in a two-entry result
// queue, so the input keeps accepting while results wait. Most commands are
// executed straight from the idle state. A set-baud request that needs a real
// division runs in the back end as a load, 26 restoring steps of the
// 48 MHz / divisor unit (one quotient bit each), and a post of the result.
// Baud words 0 and 1, and a zero divisor, resolve to fixed rates without the
// divider. No clearing pass: reset is asynchronous; queue data is not cleared.
module usb_serial_bridge_request_decoder #(
	parameter int ROM_WORDS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  usbsb_pkg::in_item_t  item,
	output logic                 empty,
	input  logic                 pop,
	output usbsb_pkg::out_item_t result
);
	usbsb_pkg::cmd_t      cmd_in;
	usbsb_pkg::cmd_t      cmd_head;
	logic                 cmd_empty;
	logic                 cmd_pop;
	logic                 res_full;
	logic                 res_push;
	usbsb_pkg::out_item_t res_data;

	// Classify the incoming beat; no state lives here
	usbsb_front u_front (
		.item (item),
		.cmd  (cmd_in)
	);

	// Hold classified commands while the back end is busy
	usbsb_fifo #(
		.item_t (usbsb_pkg::cmd_t),
		.DEPTH  (2)
	) u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.wr_data (cmd_in),
		.pop     (cmd_pop),
		.empty   (cmd_empty),
		.rd_data (cmd_head)
	);

	// Execute commands: latency timers, baud rate, frame counter, divider
	usbsb_back #(
		.ROM_WORDS (ROM_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// Hold finished results until the consumer pops them
	usbsb_fifo #(
		.item_t (usbsb_pkg::out_item_t),
		.DEPTH  (2)
	) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.full    (res_full),
		.wr_data (res_data),
		.pop     (pop),
		.empty   (empty),
		.rd_data (result)
	);

endmodule

>>> sv/usbsb_checker.sv
// ----------------------------------------------------------------------------
// usbsb_checker
// Port-level checks of the request decoder, bound to the top level.
// ----------------------------------------------------------------------------
module usbsb_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input usbsb_pkg::in_item_t  item,
	input logic                 empty,
	input logic                 pop,
	input usbsb_pkg::out_item_t result
);

	// hold a waiting result until it is popped
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed before pop");

	// line coding fields are zero without a coding write
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.coding_write) |->
		(result.line_baud == '0 && result.line_data_bits == '0
		&& result.line_parity == '0 && result.line_stop_bits == '0))
		else $error("line coding leaked without coding write");

	// no reply data without a reply length
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.reply_length == usbsb_pkg::REPLY_NONE) |->
		(result.reply_word == '0))
		else $error("reply data without reply length");

	// baud stays in range
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.coding_write) |->
		(result.line_baud <= usbsb_pkg::BAUD_MAX && result.line_baud != usbsb_pkg::BAUD_RESET))
		else $error("line baud out of range");

	// a stalled request carries no side effects
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.request_status) |->
		(result.reply_length == usbsb_pkg::REPLY_NONE && !result.purge_strobe
		&& result.modem_line_write == usbsb_pkg::LINE_NONE && !result.coding_write))
		else $error("stalled request with side effects");

endmodule

bind usb_serial_bridge_request_decoder usbsb_checker u_usbsb_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
